FILE: rtl/core/ppmv_pkg.sv
// Shared types, sizes and helpers for the per-pixel running mean/variance block.
// No dependencies; all other files of the block but ppmv_ram use this package.
package ppmv_pkg;

  localparam int Pixels     = 4096;
  localparam int IdxW       = $clog2(Pixels);
  localparam int SampleBits = 16;
  localparam int PixW       = 16;
  localparam int CountW     = 16;
  localparam int SkipW      = 4;
  localparam int MeanW      = 24;
  localparam int SpreadW    = 64;
  localparam int FpW        = 32;
  localparam int DivW       = 64;
  localparam int DsW        = 32;
  localparam int RootW      = 32;
  localparam int MulW       = 2 * MeanW;
  localparam int FifoDepth  = 4;
  localparam int FifoPtrW   = $clog2(FifoDepth);
  localparam int FifoCntW   = $clog2(FifoDepth + 1);

  localparam logic [PixW-1:0]   PixMask   = PixW'((1 << SampleBits) - 1);
  localparam logic [CountW-1:0] CountMax  = '1;
  localparam logic [SkipW-1:0]  SkipReset = SkipW'(2);
  localparam logic [SkipW-1:0]  SkipMax   = '1;
  localparam logic [MeanW-1:0]  MeanMax   = '1;

  // One accepted pixel of an accumulated frame, as handed to the back end
  typedef struct packed {
    logic [PixW-1:0]   pix;
    logic              last;
    logic [CountW-1:0] n;
  } ppmv_op_t;

  typedef struct packed {
    logic [PixW-1:0]   capture_min;
    logic [PixW-1:0]   capture_max;
    logic [MeanW-1:0]  mean_average;
    logic [MeanW-1:0]  mean_min;
    logic [MeanW-1:0]  mean_max;
    logic [MeanW-1:0]  std_average;
    logic [MeanW-1:0]  std_min;
    logic [MeanW-1:0]  std_max;
    logic [CountW-1:0] frames_accumulated;
  } ppmv_res_t;

  function automatic logic [SpreadW-1:0] sat_add64(input logic [SpreadW-1:0] a,
                                                   input logic [SpreadW-1:0] b);
    logic [SpreadW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SpreadW] ? '1 : s[SpreadW-1:0];
  endfunction

  function automatic logic [MeanW-1:0] clamp24(input logic [DivW-1:0] v);
    return (v > DivW'(MeanMax)) ? MeanMax : v[MeanW-1:0];
  endfunction

endpackage

FILE: rtl/core/ppmv_pix_if.sv
// Pixel input channel: valid/ready handshake plus one pixel item.
// Depends on ppmv_pkg for field widths.
interface ppmv_pix_if;
  logic                      valid;
  logic                      ready;
  logic [ppmv_pkg::PixW-1:0] pixel_value;
  logic                      last_in_frame;
  logic                      start_over;

  modport source(output valid, pixel_value, last_in_frame, start_over, input ready);
  modport sink(input valid, pixel_value, last_in_frame, start_over, output ready);
endinterface

FILE: rtl/core/ppmv_cfg_if.sv
// Configuration write channel carrying the skip_frames register.
// Depends on ppmv_pkg for the register width.
interface ppmv_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [ppmv_pkg::SkipW-1:0] skip_frames;

  modport source(output valid, skip_frames, input ready);
  modport sink(input valid, skip_frames, output ready);
endinterface

FILE: rtl/core/ppmv_res_if.sv
// Result output channel: valid/ready handshake plus one frame summary item.
// Depends on ppmv_pkg for field widths.
interface ppmv_res_if;
  logic                        valid;
  logic                        ready;
  logic [ppmv_pkg::PixW-1:0]   capture_min;
  logic [ppmv_pkg::PixW-1:0]   capture_max;
  logic [ppmv_pkg::MeanW-1:0]  mean_average;
  logic [ppmv_pkg::MeanW-1:0]  mean_min;
  logic [ppmv_pkg::MeanW-1:0]  mean_max;
  logic [ppmv_pkg::MeanW-1:0]  std_average;
  logic [ppmv_pkg::MeanW-1:0]  std_min;
  logic [ppmv_pkg::MeanW-1:0]  std_max;
  logic [ppmv_pkg::CountW-1:0] frames_accumulated;

  modport source(output valid, capture_min, capture_max, mean_average, mean_min, mean_max,
                 std_average, std_min, std_max, frames_accumulated, input ready);
  modport sink(input valid, capture_min, capture_max, mean_average, mean_min, mean_max,
               std_average, std_min, std_max, frames_accumulated, output ready);
endinterface

FILE: rtl/core/ppmv_ram.sv
// Generic single-port-write, registered-read RAM.
// No dependencies.
module ppmv_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

FILE: rtl/core/ppmv_front.sv
// Front end: accepts pixels and config writes, tracks frames, skip and restart.
// Depends on ppmv_pkg, ppmv_pix_if and ppmv_cfg_if.
module ppmv_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  ppmv_pix_if.sink           pix_i,
  ppmv_cfg_if.sink           cfg_i,
  input  logic               q_full_i,
  output logic               push_o,
  output ppmv_pkg::ppmv_op_t op_o
);
  logic [ppmv_pkg::SkipW-1:0]  skip_q, skip_d, skipped_q, skipped_d;
  logic [ppmv_pkg::CountW-1:0] count_q, count_d, cnt_base, cnt_now;
  logic in_frame_q, in_frame_d, taken_q, taken_d, restart_q, restart_d;
  logic acc, start, taken_now;

  assign cfg_i.ready = 1'b1;
  assign pix_i.ready = !q_full_i;
  assign acc   = pix_i.valid && pix_i.ready;
  assign start = !in_frame_q;

  always_comb begin
    taken_now = start ? (skipped_q >= skip_q) : taken_q;
    cnt_base  = (start && (pix_i.start_over || restart_q)) ? '0 : count_q;
    cnt_now   = (start && taken_now && cnt_base < ppmv_pkg::CountMax) ?
                cnt_base + ppmv_pkg::CountW'(1) : cnt_base;

    skip_d     = skip_q;
    skipped_d  = skipped_q;
    count_d    = count_q;
    in_frame_d = in_frame_q;
    taken_d    = taken_q;
    restart_d  = restart_q;

    if (cfg_i.valid && cfg_i.ready) begin
      skip_d = cfg_i.skip_frames;
    end
    if (acc) begin
      count_d = cnt_now;
      taken_d = taken_now;
      if (start) begin
        in_frame_d = 1'b1;
        restart_d  = 1'b0;
      end else if (pix_i.start_over) begin
        restart_d = 1'b1;
      end
      if (pix_i.last_in_frame) begin
        in_frame_d = 1'b0;
        if (!taken_now && skipped_q < ppmv_pkg::SkipMax) begin
          skipped_d = skipped_q + ppmv_pkg::SkipW'(1);
        end
      end
    end
  end

  // Only pixels of accumulated frames go to the back end
  assign push_o    = acc && taken_now;
  assign op_o.pix  = pix_i.pixel_value & ppmv_pkg::PixMask;
  assign op_o.last = pix_i.last_in_frame;
  assign op_o.n    = cnt_now;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_q     <= ppmv_pkg::SkipReset;
      skipped_q  <= '0;
      count_q    <= '0;
      in_frame_q <= 1'b0;
      taken_q    <= 1'b0;
      restart_q  <= 1'b0;
    end else begin
      skip_q     <= skip_d;
      skipped_q  <= skipped_d;
      count_q    <= count_d;
      in_frame_q <= in_frame_d;
      taken_q    <= taken_d;
      restart_q  <= restart_d;
    end
  end
endmodule

FILE: rtl/core/ppmv_fifo.sv
// Short first-word-fall-through queue between the front and back ends.
// Depends on ppmv_pkg.
module ppmv_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  ppmv_pkg::ppmv_op_t din_i,
  output logic               full_o,
  input  logic               pop_i,
  output ppmv_pkg::ppmv_op_t dout_o,
  output logic               empty_o
);
  ppmv_pkg::ppmv_op_t               buf_q [ppmv_pkg::FifoDepth];
  logic [ppmv_pkg::FifoPtrW-1:0]    wptr_q, rptr_q;
  logic [ppmv_pkg::FifoCntW-1:0]    cnt_q;

  assign full_o  = cnt_q == ppmv_pkg::FifoCntW'(ppmv_pkg::FifoDepth);
  assign empty_o = cnt_q == '0;
  assign dout_o  = buf_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wptr_q] <= din_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + ppmv_pkg::FifoPtrW'(1);
      end
      if (pop_i) begin
        rptr_q <= rptr_q + ppmv_pkg::FifoPtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + ppmv_pkg::FifoCntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - ppmv_pkg::FifoCntW'(1);
      end
    end
  end
endmodule

FILE: rtl/core/ppmv_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on ppmv_pkg.
module ppmv_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [ppmv_pkg::DivW-1:0] dividend_i,
  input  logic [ppmv_pkg::DsW-1:0]  divisor_i,
  output logic                      done_o,
  output logic [ppmv_pkg::DivW-1:0] quo_o
);
  localparam int CntW = $clog2(ppmv_pkg::DivW);

  logic [ppmv_pkg::DivW-1:0] quo_q;
  logic [ppmv_pkg::DsW-1:0]  rem_q, dsr_q;
  logic [ppmv_pkg::DsW:0]    shifted, diff;
  logic [CntW-1:0]           cnt_q;
  logic                      busy_q, done_q, ge;

  assign shifted = {rem_q, quo_q[ppmv_pkg::DivW-1]};
  assign ge      = shifted >= {1'b0, dsr_q};
  assign diff    = shifted - {1'b0, dsr_q};

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[ppmv_pkg::DivW-2:0], ge};
      rem_q <= ge ? diff[ppmv_pkg::DsW-1:0] : shifted[ppmv_pkg::DsW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && cnt_q == '0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(ppmv_pkg::DivW - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
endmodule

FILE: rtl/core/ppmv_sqrt.sv
// Digit-by-digit integer square root, one root bit per cycle.
// Depends on ppmv_pkg.
module ppmv_sqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [ppmv_pkg::DivW-1:0]  val_i,
  output logic                       done_o,
  output logic [ppmv_pkg::RootW-1:0] root_o
);
  localparam int CntW = $clog2(ppmv_pkg::RootW);
  localparam int RemW = ppmv_pkg::RootW + 2;

  logic [ppmv_pkg::DivW-1:0]  v_q;
  logic [ppmv_pkg::RootW-1:0] root_q;
  logic [RemW-1:0]            rem_q;
  logic [RemW+1:0]            cand, trial, diff;
  logic [CntW-1:0]            cnt_q;
  logic                       busy_q, done_q, ge;

  assign cand  = {rem_q, v_q[ppmv_pkg::DivW-1 -: 2]};
  assign trial = {2'b00, root_q, 2'b01};
  assign ge    = cand >= trial;
  assign diff  = cand - trial;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q    <= val_i;
      root_q <= '0;
      rem_q  <= '0;
    end else if (busy_q) begin
      v_q    <= {v_q[ppmv_pkg::DivW-3:0], 2'b00};
      root_q <= {root_q[ppmv_pkg::RootW-2:0], ge};
      rem_q  <= ge ? diff[RemW-1:0] : cand[RemW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && cnt_q == '0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(ppmv_pkg::RootW - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;
endmodule

FILE: rtl/core/ppmv_back.sv
// Back end: per-pixel Welford update in the mean/spread RAMs, frame statistics
// and the frame summary. Depends on ppmv_pkg, ppmv_ram, ppmv_div, ppmv_sqrt, ppmv_res_if.
module ppmv_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               empty_i,
  input  ppmv_pkg::ppmv_op_t op_i,
  output logic               pop_o,
  ppmv_res_if.source         res_o
);
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_RD   = 4'd1;
  localparam logic [3:0] ST_MDIV = 4'd2;
  localparam logic [3:0] ST_MUL  = 4'd3;
  localparam logic [3:0] ST_ADD  = 4'd4;
  localparam logic [3:0] ST_WR   = 4'd5;
  localparam logic [3:0] ST_VDIV = 4'd6;
  localparam logic [3:0] ST_FIN  = 4'd7;
  localparam logic [3:0] ST_AVGM = 4'd8;
  localparam logic [3:0] ST_AVGV = 4'd9;
  localparam logic [3:0] ST_SQA  = 4'd10;
  localparam logic [3:0] ST_SQN  = 4'd11;
  localparam logic [3:0] ST_SQX  = 4'd12;
  localparam logic [3:0] ST_OUT  = 4'd13;

  localparam int MeanW   = ppmv_pkg::MeanW;
  localparam int SpreadW = ppmv_pkg::SpreadW;
  localparam int PixW    = ppmv_pkg::PixW;
  localparam int FpW     = ppmv_pkg::FpW;
  localparam int IdxW    = ppmv_pkg::IdxW;

  logic [3:0]         state_q, state_d;
  ppmv_pkg::ppmv_op_t op_q, op_d;
  logic [IdxW-1:0]    idx_q, idx_d;
  logic [MeanW-1:0]   old_q, old_d, nm_q, nm_d, dold_q, dold_d, dnew_q, dnew_d;
  logic               neg_q, neg_d;
  logic [ppmv_pkg::MulW-1:0] prod_q, prod_d;
  logic [SpreadW-1:0] sold_q, sold_d, snew_q, snew_d;
  logic [PixW-1:0]    lo_q, lo_d, hi_q, hi_d;
  logic [FpW-1:0]     fp_q, fp_d;
  logic [SpreadW-1:0] msum_q, msum_d, vsum_q, vsum_d, vmin_q, vmin_d, vmax_q, vmax_d;
  logic [MeanW-1:0]   mmin_q, mmin_d, mmax_q, mmax_d;
  logic [MeanW-1:0]   mavg_q, mavg_d, savg_q, savg_d, smin_q, smin_d, smax_q, smax_d;
  ppmv_pkg::ppmv_res_t res_q, res_d;
  logic               res_valid_q, res_valid_d;

  logic               ram_re, ram_we;
  logic [MeanW-1:0]   mean_rd;
  logic [SpreadW-1:0] spread_rd;
  logic               div_start, div_done, sq_start, sq_done;
  logic [ppmv_pkg::DivW-1:0]  div_dividend, div_quo, sq_val;
  logic [ppmv_pkg::DsW-1:0]   div_divisor;
  logic [ppmv_pkg::RootW-1:0] sq_root;

  logic [MeanW-1:0]   x8, dold_rd, q_c, nm_c, dnew_c;
  logic               neg_rd, multi, out_free;

  ppmv_ram #(.Width(MeanW), .Depth(ppmv_pkg::Pixels)) u_mean_ram (
    .clk_i, .we_i(ram_we), .waddr_i(idx_q), .wdata_i(nm_q),
    .re_i(ram_re), .raddr_i(idx_q), .rdata_o(mean_rd)
  );

  ppmv_ram #(.Width(SpreadW), .Depth(ppmv_pkg::Pixels)) u_spread_ram (
    .clk_i, .we_i(ram_we), .waddr_i(idx_q), .wdata_i(snew_q),
    .re_i(ram_re), .raddr_i(idx_q), .rdata_o(spread_rd)
  );

  ppmv_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(div_dividend),
    .divisor_i(div_divisor), .done_o(div_done), .quo_o(div_quo)
  );

  ppmv_sqrt u_sqrt (
    .clk_i, .rst_ni, .start_i(sq_start), .val_i(sq_val), .done_o(sq_done), .root_o(sq_root)
  );

  assign x8      = {op_q.pix, {(MeanW - PixW){1'b0}}};
  assign neg_rd  = x8 < mean_rd;
  assign dold_rd = neg_rd ? mean_rd - x8 : x8 - mean_rd;
  assign q_c     = div_quo[MeanW-1:0];
  assign nm_c    = neg_q ? old_q - q_c : old_q + q_c;
  assign dnew_c  = neg_q ? nm_c - x8 : x8 - nm_c;
  assign multi   = op_q.n >= ppmv_pkg::CountW'(2);
  assign out_free = !res_valid_q || res_o.ready;

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    idx_d   = idx_q;
    old_d   = old_q;
    nm_d    = nm_q;
    dold_d  = dold_q;
    dnew_d  = dnew_q;
    neg_d   = neg_q;
    prod_d  = prod_q;
    sold_d  = sold_q;
    snew_d  = snew_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    fp_d    = fp_q;
    msum_d  = msum_q;
    mmin_d  = mmin_q;
    mmax_d  = mmax_q;
    vsum_d  = vsum_q;
    vmin_d  = vmin_q;
    vmax_d  = vmax_q;
    mavg_d  = mavg_q;
    savg_d  = savg_q;
    smin_d  = smin_q;
    smax_d  = smax_q;
    res_d   = res_q;
    res_valid_d = res_valid_q;
    pop_o     = 1'b0;
    ram_re    = 1'b0;
    ram_we    = 1'b0;
    div_start = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    sq_start  = 1'b0;
    sq_val    = '0;

    if (res_valid_q && res_o.ready) begin
      res_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          op_d    = op_i;
          ram_re  = 1'b1;
          state_d = ST_RD;
        end
      end
      ST_RD: begin
        old_d  = mean_rd;
        neg_d  = neg_rd;
        dold_d = dold_rd;
        sold_d = spread_rd;
        if (!multi) begin
          // first accumulated frame: seed the mean, zero the spread
          nm_d    = x8;
          snew_d  = '0;
          state_d = ST_WR;
        end else begin
          // round half away from zero: (2d + n) / 2n
          div_start    = 1'b1;
          div_dividend = {{(ppmv_pkg::DivW - MeanW - 1){1'b0}}, dold_rd, 1'b0} +
                         ppmv_pkg::DivW'(op_q.n);
          div_divisor  = ppmv_pkg::DsW'({op_q.n, 1'b0});
          state_d      = ST_MDIV;
        end
      end
      ST_MDIV: begin
        if (div_done) begin
          nm_d    = nm_c;
          dnew_d  = dnew_c;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_d  = ppmv_pkg::MulW'(dold_q) * ppmv_pkg::MulW'(dnew_q);
        state_d = ST_ADD;
      end
      ST_ADD: begin
        snew_d  = ppmv_pkg::sat_add64(sold_q, SpreadW'(prod_q));
        state_d = ST_WR;
      end
      ST_WR: begin
        ram_we = 1'b1;
        if (op_q.pix < lo_q) lo_d = op_q.pix;
        if (op_q.pix > hi_q) hi_d = op_q.pix;
        if (fp_q != '1) fp_d = fp_q + FpW'(1);
        idx_d = (idx_q == IdxW'(ppmv_pkg::Pixels - 1)) ? '0 : idx_q + IdxW'(1);
        if (multi) begin
          div_start    = 1'b1;
          div_dividend = snew_q;
          div_divisor  = ppmv_pkg::DsW'(op_q.n - ppmv_pkg::CountW'(1));
          state_d      = ST_VDIV;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_VDIV: begin
        if (div_done) begin
          msum_d = ppmv_pkg::sat_add64(msum_q, SpreadW'(nm_q));
          if (nm_q < mmin_q) mmin_d = nm_q;
          if (nm_q > mmax_q) mmax_d = nm_q;
          vsum_d = ppmv_pkg::sat_add64(vsum_q, div_quo);
          if (div_quo < vmin_q) vmin_d = div_quo;
          if (div_quo > vmax_q) vmax_d = div_quo;
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!op_q.last) begin
          state_d = ST_IDLE;
        end else if (multi) begin
          div_start    = 1'b1;
          div_dividend = msum_q;
          div_divisor  = fp_q;
          state_d      = ST_AVGM;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_AVGM: begin
        if (div_done) begin
          mavg_d       = ppmv_pkg::clamp24(div_quo);
          div_start    = 1'b1;
          div_dividend = vsum_q;
          div_divisor  = fp_q;
          state_d      = ST_AVGV;
        end
      end
      ST_AVGV: begin
        if (div_done) begin
          sq_start = 1'b1;
          sq_val   = div_quo;
          state_d  = ST_SQA;
        end
      end
      ST_SQA: begin
        if (sq_done) begin
          savg_d   = ppmv_pkg::clamp24(ppmv_pkg::DivW'(sq_root));
          sq_start = 1'b1;
          sq_val   = vmin_q;
          state_d  = ST_SQN;
        end
      end
      ST_SQN: begin
        if (sq_done) begin
          smin_d   = ppmv_pkg::clamp24(ppmv_pkg::DivW'(sq_root));
          sq_start = 1'b1;
          sq_val   = vmax_q;
          state_d  = ST_SQX;
        end
      end
      ST_SQX: begin
        if (sq_done) begin
          smax_d  = ppmv_pkg::clamp24(ppmv_pkg::DivW'(sq_root));
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          res_d.capture_min        = lo_q;
          res_d.capture_max        = hi_q;
          res_d.mean_average       = mavg_q;
          res_d.mean_min           = mmin_q;
          res_d.mean_max           = mmax_q;
          res_d.std_average        = savg_q;
          res_d.std_min            = smin_q;
          res_d.std_max            = smax_q;
          res_d.frames_accumulated = op_q.n;
          res_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // frame end: start the next frame's statistics from scratch
    if ((state_q == ST_FIN && op_q.last && !multi) || (state_q == ST_OUT && out_free)) begin
      lo_d   = '1;
      hi_d   = '0;
      fp_d   = '0;
      msum_d = '0;
      mmin_d = ppmv_pkg::MeanMax;
      mmax_d = '0;
      vsum_d = '0;
      vmin_d = '1;
      vmax_d = '0;
      idx_d  = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    old_q  <= old_d;
    nm_q   <= nm_d;
    dold_q <= dold_d;
    dnew_q <= dnew_d;
    neg_q  <= neg_d;
    prod_q <= prod_d;
    sold_q <= sold_d;
    snew_q <= snew_d;
    mavg_q <= mavg_d;
    savg_q <= savg_d;
    smin_q <= smin_d;
    smax_q <= smax_d;
    res_q  <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      lo_q        <= '1;
      hi_q        <= '0;
      fp_q        <= '0;
      msum_q      <= '0;
      mmin_q      <= ppmv_pkg::MeanMax;
      mmax_q      <= '0;
      vsum_q      <= '0;
      vmin_q      <= '1;
      vmax_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      lo_q        <= lo_d;
      hi_q        <= hi_d;
      fp_q        <= fp_d;
      msum_q      <= msum_d;
      mmin_q      <= mmin_d;
      mmax_q      <= mmax_d;
      vsum_q      <= vsum_d;
      vmin_q      <= vmin_d;
      vmax_q      <= vmax_d;
      res_valid_q <= res_valid_d;
    end
  end

  assign res_o.valid              = res_valid_q;
  assign res_o.capture_min        = res_q.capture_min;
  assign res_o.capture_max        = res_q.capture_max;
  assign res_o.mean_average       = res_q.mean_average;
  assign res_o.mean_min           = res_q.mean_min;
  assign res_o.mean_max           = res_q.mean_max;
  assign res_o.std_average        = res_q.std_average;
  assign res_o.std_min            = res_q.std_min;
  assign res_o.std_max            = res_q.std_max;
  assign res_o.frames_accumulated = res_q.frames_accumulated;
endmodule

FILE: rtl/core/per_pixel_running_mean_variance.sv
// In the back end the first pixel (n = 1) passes ST_IDLE, ST_RD, ST_WR and ST_FIN;
// later pixels make two passes through the shared 64-step divider.
// A frame's last pixel with n >= 2 adds two divides and three 32-step square roots.
// Reset (rst_ni, async low) clears all control and statistics; the mean and spread RAMs
// are not cleared and hold valid data only where a frame has written them.
module per_pixel_running_mean_variance (
  input  logic       clk_i,
  input  logic       rst_ni,
  ppmv_pix_if.sink   pix_i,
  ppmv_cfg_if.sink   cfg_i,
  ppmv_res_if.source res_o
);
  // Front end classifies each pixel: skipped frame, restart, frame count.
  // Only pixels of accumulated frames enter the queue, tagged with their count n.
  logic               push, pop, q_full, q_empty;
  ppmv_pkg::ppmv_op_t op_in, op_out;

  ppmv_front u_front (
    .clk_i, .rst_ni, .pix_i, .cfg_i,
    .q_full_i(q_full), .push_o(push), .op_o(op_in)
  );

  // Queue lets the front take pixels until it fills while the back end iterates
  ppmv_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i(push), .din_i(op_in), .full_o(q_full),
    .pop_i(pop), .dout_o(op_out), .empty_o(q_empty)
  );

  // Back end does the per-pixel Welford update, frame statistics and the summary;
  // its output register holds a finished result while the next pixels proceed.
  ppmv_back u_back (
    .clk_i, .rst_ni,
    .empty_i(q_empty), .op_i(op_out), .pop_o(pop), .res_o
  );

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_full) else $error("queue overflow");

  a_no_pop_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_empty) else $error("queue underflow");
endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for per_pixel_running_mean_variance: directed frames, then random frames.
// Depends on ppmv_pkg and the pixel, config and result interfaces of the block.
module tb_top;

  localparam int WatchLimit = 40000;  // idle cycles before the run is declared hung
  localparam int DrainWait  = 3000;   // covers a full back-end pipeline plus the pixel queue
  localparam int HoldCycles = 12000;  // long receiver hold-off to back the block up
  localparam int PhaseItems = 190;
  localparam int SeedLen    = 48;     // longer than any random frame

  logic clk_i;
  logic rst_ni;

  ppmv_pix_if pix_if();
  ppmv_cfg_if cfg_if();
  ppmv_res_if res_if();

  per_pixel_running_mean_variance u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .pix_i (pix_if),
    .cfg_i (cfg_if),
    .res_o (res_if)
  );

  // Shadow of the block's statistics state
  logic [ppmv_pkg::MeanW-1:0]   mean_mem [ppmv_pkg::Pixels];
  logic [ppmv_pkg::SpreadW-1:0] spread_mem [ppmv_pkg::Pixels];
  logic [ppmv_pkg::SkipW-1:0]   skip_cfg;
  int unsigned        n_frames;
  int unsigned        n_skipped;
  int unsigned        pos;
  logic [ppmv_pkg::PixW-1:0]    cap_lo, cap_hi;
  logic [63:0]        msum, mlo, mhi, vsum, vlo, vhi;
  logic [31:0]        frame_pix;
  bit                 mid_frame, taken, restart_held;
  int unsigned        filled;      // leading store entries already written since reset

  ppmv_pkg::ppmv_res_t summary_q[$];
  int        errs;
  int        idle_cycles;
  bit        calm;
  bit        hold_req;

  // Directed frames; rows with has_res carry a summary that is easy to derive by hand
  typedef struct {
    logic [ppmv_pkg::PixW-1:0] pix;
    bit                        last;
    bit                        so;
    bit                        has_res;
    ppmv_pkg::ppmv_res_t       res;
  } stim_row_t;

  stim_row_t dir_rows[$];

  function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  function automatic logic [ppmv_pkg::MeanW-1:0] to24(input logic [63:0] v);
    return (v > 64'hFF_FFFF) ? ppmv_pkg::MeanMax : v[ppmv_pkg::MeanW-1:0];
  endfunction

  // Integer square root by digit-pair refinement
  function automatic logic [63:0] root64(input logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'h1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic void clear_stats();
    cap_lo = '1; cap_hi = '0;
    msum = 0; mlo = 64'hFF_FFFF; mhi = 0;
    vsum = 0; vlo = '1; vhi = 0;
    frame_pix = 0; pos = 0; mid_frame = 0;
  endfunction

  function automatic void reset_shadow();
    skip_cfg = ppmv_pkg::SkipReset;
    n_frames = 0; n_skipped = 0;
    taken = 0; restart_held = 0; filled = 0;
    clear_stats();
  endfunction

  // Advance the shadow by one accepted pixel; return 1 when a frame summary is due
  function automatic bit predict_pixel(input logic [ppmv_pkg::PixW-1:0] p, input bit last,
                                       input bit so, output ppmv_pkg::ppmv_res_t r);
    logic [31:0] x8, old, nm;
    logic [63:0] dold, dnew, q, m, v;
    bit          neg;
    bit          got;
    got = 0;
    r = '0;
    if (!mid_frame) begin
      mid_frame = 1;
      taken = n_skipped >= skip_cfg;
      if (so || restart_held) begin
        n_frames = 0;
        restart_held = 0;
      end
      if (taken && n_frames < 65535) n_frames++;
    end else if (so) begin
      restart_held = 1;
    end
    if (taken) begin
      x8 = {8'b0, p & ppmv_pkg::PixMask, 8'b0};
      if (n_frames <= 1) begin
        mean_mem[pos] = x8[ppmv_pkg::MeanW-1:0];
        spread_mem[pos] = 0;
        if (pos + 1 > filled) filled = pos + 1;
      end else begin
        old = {8'b0, mean_mem[pos]};
        neg = x8 < old;
        dold = neg ? old - x8 : x8 - old;
        q = (2 * dold + n_frames) / (2 * 64'(n_frames));
        nm = neg ? old - q[31:0] : old + q[31:0];
        dnew = neg ? nm - x8 : x8 - nm;
        mean_mem[pos] = nm[ppmv_pkg::MeanW-1:0];
        spread_mem[pos] = add_sat(spread_mem[pos], dold * dnew);
      end
      if (p < cap_lo) cap_lo = p;
      if (p > cap_hi) cap_hi = p;
      if (frame_pix != '1) frame_pix++;
      if (n_frames >= 2) begin
        m = mean_mem[pos];
        v = spread_mem[pos] / 64'(n_frames - 1);
        msum = add_sat(msum, m);
        if (m < mlo) mlo = m;
        if (m > mhi) mhi = m;
        vsum = add_sat(vsum, v);
        if (v < vlo) vlo = v;
        if (v > vhi) vhi = v;
      end
      pos = (pos + 1 >= ppmv_pkg::Pixels) ? 0 : pos + 1;
    end
    if (last) begin
      if (taken && n_frames >= 2 && frame_pix != 0) begin
        r.capture_min        = cap_lo;
        r.capture_max        = cap_hi;
        r.mean_average       = to24(msum / frame_pix);
        r.mean_min           = mlo[ppmv_pkg::MeanW-1:0];
        r.mean_max           = mhi[ppmv_pkg::MeanW-1:0];
        r.std_average        = to24(root64(vsum / frame_pix));
        r.std_min            = to24(root64(vlo));
        r.std_max            = to24(root64(vhi));
        r.frames_accumulated = n_frames[ppmv_pkg::CountW-1:0];
        got = 1;
      end else if (!taken && n_skipped < 15) begin
        n_skipped++;
      end
      clear_stats();
    end
    return got;
  endfunction

  // Clock
  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // Offer one pixel item, with an optional random gap ahead of it; predict on acceptance
  task automatic send_pixel(input logic [ppmv_pkg::PixW-1:0] p, input bit last, input bit so,
                            input bit typed, input ppmv_pkg::ppmv_res_t typed_res);
    ppmv_pkg::ppmv_res_t r;
    bit        got;
    if (!calm && $urandom_range(0, 5) == 0) begin
      pix_if.valid = 0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    pix_if.valid         = 1;
    pix_if.pixel_value   = p;
    pix_if.last_in_frame = last;
    pix_if.start_over    = so;
    do @(posedge clk_i); while (!pix_if.ready);
    got = predict_pixel(p, last, so, r);
    if (typed) summary_q.push_back(typed_res);
    else if (got) summary_q.push_back(r);
    @(negedge clk_i);
    pix_if.valid = 0;
  endtask

  // Drain every pending summary, then let the back end settle before touching config
  task automatic wait_idle();
    wait (summary_q.size() == 0);
    repeat (DrainWait) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_skip(input logic [ppmv_pkg::SkipW-1:0] v);
    cfg_if.valid       = 1;
    cfg_if.skip_frames = v;
    do @(posedge clk_i); while (!cfg_if.ready);
    skip_cfg = v;
    @(negedge clk_i);
    cfg_if.valid = 0;
  endtask

  function automatic logic [ppmv_pkg::PixW-1:0] pick_pixel();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return ppmv_pkg::PixW'($urandom_range(0, 65535));
    endcase
  endfunction

  // One random frame; keep accumulating frames inside the store area already written
  task automatic send_frame(input int want_len, output int sent);
    bit          so_first, will_take;
    int unsigned n_next;
    int          len;
    ppmv_pkg::ppmv_res_t none;
    none = '0;
    so_first = ($urandom_range(0, 9) == 0);
    will_take = n_skipped >= skip_cfg;
    n_next = (so_first || restart_held) ? 0 : n_frames;
    if (will_take && n_next < 65535) n_next++;
    len = want_len;
    if (will_take && n_next >= 2 && len > filled) len = filled;
    if (len < 1) len = 1;
    for (int i = 0; i < len; i++) begin
      send_pixel(pick_pixel(), i == len - 1,
                 (i == 0) ? so_first : ($urandom_range(0, 19) == 0), 0, none);
    end
    sent = len;
  endtask

  task automatic cmp_field(input string name, input logic [31:0] e, input logic [31:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, e, a);
      errs++;
    end
  endtask

  // Check each accepted summary against the oldest expectation
  always @(posedge clk_i) begin
    ppmv_pkg::ppmv_res_t e;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (summary_q.size() == 0) begin
        $display("%0t: unexpected summary, expected none, got min %h max %h count %0d",
                 $time, res_if.capture_min, res_if.capture_max, res_if.frames_accumulated);
        errs++;
      end else begin
        e = summary_q.pop_front();
        cmp_field("capture_min", e.capture_min, res_if.capture_min);
        cmp_field("capture_max", e.capture_max, res_if.capture_max);
        cmp_field("mean_average", e.mean_average, res_if.mean_average);
        cmp_field("mean_min", e.mean_min, res_if.mean_min);
        cmp_field("mean_max", e.mean_max, res_if.mean_max);
        cmp_field("std_average", e.std_average, res_if.std_average);
        cmp_field("std_min", e.std_min, res_if.std_min);
        cmp_field("std_max", e.std_max, res_if.std_max);
        cmp_field("frames_accumulated", e.frames_accumulated, res_if.frames_accumulated);
      end
    end
  end

  // Watchdog: count cycles in which no item moves on any channel
  always @(posedge clk_i) begin
    if ((pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchLimit) begin
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  // Receiver: random stall bursts, one long hold-off on request, none once calm
  initial begin
    res_if.ready = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        res_if.ready = 0;
        repeat (HoldCycles - 1) @(negedge clk_i);
        hold_req = 0;
      end else if (!calm && $urandom_range(0, 6) == 0) begin
        res_if.ready = 0;
        repeat ($urandom_range(1, 4) - 1) @(negedge clk_i);
      end else begin
        res_if.ready = 1;
      end
    end
  end

  task automatic add_row(input logic [ppmv_pkg::PixW-1:0] p, input bit last, input bit so);
    stim_row_t row;
    row.pix = p; row.last = last; row.so = so; row.has_res = 0; row.res = '0;
    dir_rows.push_back(row);
  endtask

  initial begin
    stim_row_t                  row;
    logic [ppmv_pkg::SkipW-1:0] phase_skip[5];
    int                         items, sent;
    ppmv_pkg::ppmv_res_t        none;
    none = '0;
    errs = 0; idle_cycles = 0; calm = 0; hold_req = 0;
    rst_ni = 0;
    pix_if.valid = 0; pix_if.pixel_value = 0; pix_if.last_in_frame = 0; pix_if.start_over = 0;
    cfg_if.valid = 0; cfg_if.skip_frames = 0;
    reset_shadow();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // Two frames skipped at reset, a first frame that only seeds, then an extreme pair:
    // pixel 0 stays black and pixel 1 stays white, so the variance is zero everywhere.
    add_row(16'd10, 0, 0); add_row(16'd20, 1, 0);
    add_row(16'd30, 1, 0);
    add_row(16'h0000, 0, 0); add_row(16'hFFFF, 1, 0);
    add_row(16'h0000, 0, 0); add_row(16'hFFFF, 1, 0);
    dir_rows[dir_rows.size() - 1].has_res = 1;
    dir_rows[dir_rows.size() - 1].res = '{capture_min: 16'h0000, capture_max: 16'hFFFF,
      mean_average: 24'h7FFF80, mean_min: 24'h000000, mean_max: 24'hFFFF00,
      std_average: 24'h0, std_min: 24'h0, std_max: 24'h0, frames_accumulated: 16'd2};
    // Restart raised mid-frame takes hold at the next frame, which seeds again
    add_row(16'd7, 0, 0); add_row(16'd9, 1, 1);
    add_row(16'd5, 0, 0); add_row(16'd6, 1, 0);
    add_row(16'hFFFF, 0, 0); add_row(16'h0000, 1, 0);
    // Restart on a first pixel, then two single-pixel frames and a two-pixel frame
    add_row(16'd1, 0, 1); add_row(16'd2, 1, 0);
    add_row(16'h8000, 1, 0);
    add_row(16'h7FFF, 1, 0);
    add_row(16'h5555, 0, 0); add_row(16'hAAAA, 1, 0);

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      send_pixel(row.pix, row.last, row.so, row.has_res, row.res);
    end

    // Random phases: extremes of skip_frames first, the last phase without idling
    phase_skip[0] = '0;
    phase_skip[1] = ppmv_pkg::SkipMax;
    phase_skip[2] = ppmv_pkg::SkipW'($urandom_range(1, 14));
    phase_skip[3] = 4'd3;
    phase_skip[4] = '0;
    for (int ph = 0; ph < 5; ph++) begin
      wait_idle();
      write_skip(phase_skip[ph]);
      if (ph == 4) calm = 1;
      if (ph == 0) begin
        // Seed the leading store entries in one frame longer than any random frame
        for (int i = 0; i < SeedLen; i++)
          send_pixel(pick_pixel(), i == SeedLen - 1, i == 0, 0, none);
      end
      if (ph == 2) hold_req = 1;
      items = 0;
      while (items < PhaseItems - 45 * (ph == 4 ? 3 : 0)) begin
        send_frame(($urandom_range(0, 15) == 0) ? $urandom_range(13, 40)
                                                : $urandom_range(1, 12), sent);
        items += sent;
      end
    end

    wait (summary_q.size() == 0);
    repeat (DrainWait) @(posedge clk_i);
    if (errs == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

FILE: per_pixel_running_mean_variance.f
rtl/core/ppmv_pkg.sv
rtl/core/ppmv_pix_if.sv
rtl/core/ppmv_cfg_if.sv
rtl/core/ppmv_res_if.sv
rtl/core/ppmv_ram.sv
rtl/core/ppmv_front.sv
rtl/core/ppmv_fifo.sv
rtl/core/ppmv_div.sv
rtl/core/ppmv_sqrt.sv
rtl/core/ppmv_back.sv
rtl/core/per_pixel_running_mean_variance.sv
verif/tb_top.sv
